// ===== design/leb_pkg.sv =====
// Shared types and constants for the LEB128 stream decoder.
// No dependencies; used by leb_step and leb128_stream_decoder.
package leb_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 4;

  // Length limits in bytes
  localparam logic [CountW-1:0] MaxBytes     = 4'd10;
  localparam logic [CountW-1:0] Word32SLimit = 4'd4;
  localparam logic [CountW-1:0] Word32ULimit = 4'd5;
  // Unsigned 32-bit form keeps only the low nibble of this byte
  localparam logic [CountW-1:0] Word32UTail  = 4'd5;

  // Configuration register indexes
  localparam logic CfgSignedIdx = 1'b0;
  localparam logic CfgWord32Idx = 1'b1;

  typedef struct packed {
    logic signed_mode;
    logic word32_mode;
  } cfg_t;

  typedef struct packed {
    logic              emit;
    logic              too_long;
    logic [ValueW-1:0] value;
    logic [CountW-1:0] count;
    logic [ValueW-1:0] acc_next;
    logic [CountW-1:0] seen_next;
  } step_t;

endpackage

// ===== design/leb_step.sv =====
// Combinational step of the LEB128 decoder: folds one byte into the accumulator.
// Depends on leb_pkg (cfg_t, step_t, length limits).
module leb_step (
  input  leb_pkg::cfg_t                    cfg_i,
  input  logic [7:0]                       byte_i,
  input  logic [leb_pkg::ValueW-1:0]       acc_i,
  input  logic [leb_pkg::CountW-1:0]       seen_i,
  output leb_pkg::step_t                   step_o
);

  logic [leb_pkg::CountW-1:0] n;
  logic [leb_pkg::CountW-1:0] limit;
  logic                       more;
  logic [6:0]                 shift;
  logic [6:0]                 top;
  logic [6:0]                 group;
  logic [leb_pkg::ValueW-1:0] shifted;
  logic [leb_pkg::ValueW-1:0] acc_new;
  logic [leb_pkg::ValueW-1:0] ext_mask;

  always_comb begin
    n     = seen_i + leb_pkg::CountW'(1);
    more  = byte_i[7];
    if (cfg_i.word32_mode) begin
      limit = cfg_i.signed_mode ? leb_pkg::Word32SLimit : leb_pkg::Word32ULimit;
    end else begin
      limit = leb_pkg::MaxBytes;
    end

    // 7 bits per group, least significant group first
    shift = 7'({3'b000, n - leb_pkg::CountW'(1)} * 7'd7);
    top   = shift + 7'd7;

    if (cfg_i.word32_mode && !cfg_i.signed_mode && n == leb_pkg::Word32UTail) begin
      group = {3'b000, byte_i[3:0]};
    end else begin
      group = byte_i[6:0];
    end

    shifted  = (shift < 7'd64) ? ({57'b0, group} << shift[5:0]) : '0;
    acc_new  = acc_i | shifted;
    // no extension once the groups already fill the word
    ext_mask = (cfg_i.signed_mode && byte_i[6] && top < 7'd64) ?
               ({leb_pkg::ValueW{1'b1}} << top[5:0]) : '0;

    step_o.emit      = 1'b0;
    step_o.too_long  = 1'b0;
    step_o.value     = acc_new | ext_mask;
    step_o.count     = n;
    step_o.acc_next  = '0;
    step_o.seen_next = '0;

    priority if (n > limit || (n == limit && more)) begin
      step_o.emit     = 1'b1;
      step_o.too_long = 1'b1;
      step_o.value    = '0;
      step_o.count    = (n > limit) ? n : limit;
    end else if (more) begin
      step_o.acc_next  = acc_new;
      step_o.seen_next = n;
    end else begin
      step_o.emit = 1'b1;
    end
  end

endmodule

// ===== design/leb128_stream_decoder.sv =====
// Top level of the LEB128 stream decoder: input register, state, result register.
// Depends on leb_pkg and leb_step.
//
// Decodes a stream of LEB128 bytes, one byte per clock cycle unless stalled. An
// accepted byte sits in an input register while leb_step folds it into the
// accumulator; a byte that ends a number (or breaks the length limit) loads
// the result register. The input stalls only when a staged byte ends a number
// and the previous result has not been taken yet. Results carry the 64-bit
// value, the byte count and a too-long flag (value then zero). Configuration
// (index 0: signed mode, index 1: 32-bit word mode) must be written only while
// idle, by the user; the block itself does not enforce this.
module leb128_stream_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic                        cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  in_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [leb_pkg::ValueW-1:0]  decoded_value_o,
  output logic [leb_pkg::CountW-1:0]  byte_count_o,
  output logic                        too_long_o
);

  leb_pkg::cfg_t              cfg_q;
  logic                       in_valid_q;
  logic [7:0]                 in_byte_q;
  logic [leb_pkg::ValueW-1:0] acc_q;
  logic [leb_pkg::CountW-1:0] seen_q;
  logic                       out_valid_q;
  logic [leb_pkg::ValueW-1:0] value_q;
  logic [leb_pkg::CountW-1:0] count_q;
  logic                       too_long_q;

  leb_pkg::step_t step;
  logic           out_free;
  logic           advance;

  leb_step u_step (
    .cfg_i  (cfg_q),
    .byte_i (in_byte_q),
    .acc_i  (acc_q),
    .seen_i (seen_q),
    .step_o (step)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!step.emit || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        leb_pkg::CfgSignedIdx: cfg_q.signed_mode <= cfg_data_i;
        leb_pkg::CfgWord32Idx: cfg_q.word32_mode <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      seen_q <= '0;
    end else if (advance) begin
      acc_q  <= step.acc_next;
      seen_q <= step.seen_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && step.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step.emit) begin
      value_q    <= step.value;
      count_q    <= step.count;
      too_long_q <= step.too_long;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign decoded_value_o = value_q;
  assign byte_count_o    = count_q;
  assign too_long_o      = too_long_q;

`ifndef ASSERT_OFF
  a_too_long_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_long_o |-> decoded_value_o == '0)
    else $error("too-long result with nonzero value");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_count_o != '0 && byte_count_o <= leb_pkg::MaxBytes)
    else $error("byte count out of range");

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q < leb_pkg::MaxBytes)
    else $error("bytes seen reached the limit");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && step.emit |=> seen_q == '0 && acc_q == '0)
    else $error("state not cleared after a result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(advance && step.emit))
    else $error("pending result overwritten");
`endif

endmodule
